// ===== design/ptt_pkg.sv =====
package ptt_pkg;

  // Table size default and the most events that one tick can report.
  localparam int MAX_TIMERS_DEF = 16;
  localparam int RES_LIMIT      = 16;

  // Configuration register indexes and their reset values.
  localparam logic [0:0] CFG_TICK_MS      = 1'b0;
  localparam logic [0:0] CFG_MIN_INTERVAL = 1'b1;
  localparam logic [9:0]  TICK_MS_RESET      = 10'd10;
  localparam logic [15:0] MIN_INTERVAL_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_KILL  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BELOW_MIN = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } st_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FIRED  = 1'b1
  } kind_t;

  // One timer as held in the table memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] last_fire;
  } entry_t;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    st_t        status;
    logic [7:0] fired_id;
    logic       last;
  } res_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// ===== design/ptt_in_if.sv =====
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  tmr_id;
  logic [31:0] interval;

  modport source (output valid, output operation, output tmr_id, output interval,
                  input ready);
  modport sink (input valid, input operation, input tmr_id, input interval,
                output ready);
endinterface

// ===== design/ptt_out_if.sv =====
interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [7:0] fired_id;
  logic       last;

  modport source (output valid, output kind, output status, output fired_id, output last,
                  input ready);
  modport sink (input valid, input kind, input status, input fired_id, input last,
                output ready);
endinterface

// ===== design/ptt_ram.sv =====
module ptt_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ptt_out_stage.sv =====
module ptt_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  ptt_pkg::push_t push,
  output logic          push_free,
  ptt_out_if.source     out_ch
);
  import ptt_pkg::*;

  logic out_valid_r;
  res_t res_r;

  // The register can take a new result when empty or when its content transfers now.
  assign push_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      res_r <= push.res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = res_r.kind;
  assign out_ch.status   = res_r.status;
  assign out_ch.fired_id = res_r.fired_id;
  assign out_ch.last     = res_r.last;

endmodule

// ===== design/ptt_seq.sv =====
module ptt_seq #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptt_pkg::op_t         in_op,
  input  logic [7:0]           in_id,
  input  logic [31:0]          in_interval,
  input  logic [9:0]           tick_ms,
  input  logic [15:0]          min_interval,
  output ptt_pkg::push_t       push,
  input  logic                 push_free,
  output logic                 ram_we,
  output logic [((MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1)-1:0] ram_waddr,
  output ptt_pkg::entry_t      ram_wdata,
  output logic [((MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1)-1:0] ram_raddr,
  input  ptt_pkg::entry_t      ram_rdata
);
  import ptt_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int EW = $clog2(RES_LIMIT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_FLUSH
  } state_t;

  state_t          state_r;
  op_t             op_r;
  logic [7:0]      id_r;
  logic [31:0]     ivl_r;
  logic [31:0]     time_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r;
  logic            found_r;
  logic            pend_v_r;
  logic [7:0]      pend_id_r;
  logic [EW-1:0]   ev_cnt_r;
  st_t             status_r;

  logic            accept;
  logic            in_range;
  logic [31:0]     elapsed;
  logic            due;
  logic            adv;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   count_dec;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // The entry at idx_r sits on the memory read data during a scan.
  assign in_range  = (idx_r < count_r);
  assign elapsed   = time_r - ram_rdata.last_fire;
  assign due       = (op_r == OP_TICK) && (elapsed >= ram_rdata.period)
                     && (ev_cnt_r < EW'(RES_LIMIT));
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign count_dec = count_r - CW'(found_r);

  // A due timer waits while an earlier event cannot yet leave.
  assign adv = (state_r == S_SCAN) && in_range && !(due && pend_v_r && !push_free);

  // Read address: entry 0 while idle, else the next entry or the same one on a stall.
  always_comb begin
    if (state_r == S_IDLE) begin
      ram_raddr = '0;
    end else if (adv) begin
      ram_raddr = idx_inc[AW-1:0];
    end else begin
      ram_raddr = idx_r[AW-1:0];
    end
  end

  // Table writes: fire-time update, compaction after a removal, or the appended timer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    if (adv && due) begin
      ram_we              = 1'b1;
      ram_wdata.last_fire = ram_rdata.last_fire + ram_rdata.period;
    end else if (adv && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = idx_dec[AW-1:0];
    end else if ((state_r == S_SCAN) && !in_range && (op_r == OP_SET)
                 && (count_dec < CW'(MAX_TIMERS))) begin
      ram_we              = 1'b1;
      ram_waddr           = count_dec[AW-1:0];
      ram_wdata.id        = id_r;
      ram_wdata.period    = ivl_r;
      ram_wdata.last_fire = time_r;
    end
  end

  // Results toward the output register, offered only when it can take them.
  always_comb begin
    push = '0;
    case (state_r)
      S_SCAN: begin
        if (adv && due && pend_v_r) begin
          push.valid        = 1'b1;
          push.res.kind     = KIND_FIRED;
          push.res.status   = ST_OK;
          push.res.fired_id = pend_id_r;
          push.res.last     = 1'b0;
        end
      end
      S_RESP: begin
        push.valid        = push_free;
        push.res.kind     = KIND_STATUS;
        push.res.status   = status_r;
        push.res.fired_id = '0;
        push.res.last     = 1'b1;
      end
      S_FLUSH: begin
        push.valid        = push_free;
        push.res.kind     = KIND_FIRED;
        push.res.status   = ST_OK;
        push.res.fired_id = pend_id_r;
        push.res.last     = 1'b1;
      end
      default: begin
        push = '0;
      end
    endcase
  end

  // Sequencer: state and the registers it steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      time_r   <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
      ev_cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            id_r     <= in_id;
            ivl_r    <= in_interval;
            idx_r    <= '0;
            found_r  <= 1'b0;
            pend_v_r <= 1'b0;
            ev_cnt_r <= '0;
            case (in_op)
              OP_SET: begin
                if (in_interval < {16'd0, min_interval}) begin
                  status_r <= ST_BELOW_MIN;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              OP_KILL: begin
                state_r <= S_SCAN;
              end
              OP_TICK: begin
                time_r  <= time_r + 32'(tick_ms);
                state_r <= S_SCAN;
              end
              default: begin
                count_r  <= '0;
                status_r <= ST_OK;
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (in_range) begin
            if (adv) begin
              idx_r <= idx_inc;
              if (due) begin
                pend_v_r  <= 1'b1;
                pend_id_r <= ram_rdata.id;
                ev_cnt_r  <= ev_cnt_r + EW'(1);
              end
              if ((op_r != OP_TICK) && !found_r && (ram_rdata.id == id_r)) begin
                found_r <= 1'b1;
              end
            end
          end else begin
            case (op_r)
              OP_TICK: begin
                state_r <= pend_v_r ? S_FLUSH : S_IDLE;
              end
              OP_KILL: begin
                count_r  <= count_dec;
                status_r <= found_r ? ST_OK : ST_NOT_FOUND;
                state_r  <= S_RESP;
              end
              OP_SET: begin
                if (count_dec < CW'(MAX_TIMERS)) begin
                  count_r  <= count_dec + CW'(1);
                  status_r <= ST_OK;
                end else begin
                  count_r  <= count_dec;
                  status_r <= ST_FULL;
                end
                state_r <= S_RESP;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_RESP, S_FLUSH: begin
          if (push_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TIMERS))
    else $error("timer count above table size");

  // No table write happens while waiting for an item.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("table write while idle");

  // A result is only handed over when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> push_free)
    else $error("result pushed into a full output register");

  // A tick never reports more events than the limit.
  a_event_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= EW'(RES_LIMIT))
    else $error("event count above limit");

  // A clear empties the table at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries in the table");

endmodule

// ===== design/periodic_timer_table_core.sv =====
// Periodic timer table. Items on in_ch carry an operation (set, kill, tick,
// clear), a timer id and an interval; results leave on out_ch. A transfer on
// either channel happens on a rising clk edge with valid and ready both high.
// Set, kill and clear each give one status result with last set. A tick adds
// tick_ms to the ms counter and gives one fired event per expired timer in
// table order (at most 16), the final one marked last; a tick on which nothing
// expires gives no result. Registers are written through cfg_we, cfg_index
// (0 tick_ms, 1 min_interval) and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. One item
// is handled at a time and in_ch.ready is low meanwhile. A scan walks the
// table one entry per cycle through a single-port-read table memory, unless
// a due timer must wait for an earlier event that cannot yet leave because
// out_ch is stalled. The output register lets the next item be taken while a
// result still waits. A synchronous reset (rst_n low) empties the table,
// zeroes the ms counter and restores tick_ms to 10 and min_interval to 100;
// no memory clearing pass runs.
module periodic_timer_table_core #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptt_in_if.sink      in_ch,
  ptt_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ptt_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  logic [9:0]    tick_ms_r;
  logic [15:0]   min_interval_r;
  push_t         push;
  logic          push_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r      <= TICK_MS_RESET;
      min_interval_r <= MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_MS:      tick_ms_r      <= cfg_data[9:0];
        CFG_MIN_INTERVAL: min_interval_r <= cfg_data;
        default:          tick_ms_r      <= tick_ms_r;
      endcase
    end
  end

  ptt_seq #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_op        (op_t'(in_ch.operation)),
    .in_id        (in_ch.tmr_id),
    .in_interval  (in_ch.interval),
    .tick_ms      (tick_ms_r),
    .min_interval (min_interval_r),
    .push         (push),
    .push_free    (push_free),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  ptt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_free (push_free),
    .out_ch    (out_ch)
  );

endmodule
